// ===== sv/tsm_pkg.sv =====
// Shared types and constants for the two-stack shared-memory core.
package tsm_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;

  typedef enum logic [2:0] {
    OP_PUSH_A = 3'd0,
    OP_PUSH_B = 3'd1,
    OP_POP_A  = 3'd2,
    OP_POP_B  = 3'd3,
    OP_DUMP_A = 3'd4,
    OP_DUMP_B = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic load;      // Capture the incoming beat.
    logic exec;      // Execute the captured operation.
    logic pop_out;   // Send the word fetched by a pop.
    logic dump_out;  // Send the pending dump word and fetch the next.
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // Output register can take a beat this cycle.
    logic pop_rd;     // Captured operation is a pop of a non-empty stack.
    logic dump_rd;    // Captured operation is a dump of a non-empty stack.
    logic dump_last;  // Pending dump word is the final one.
  } sts_t;

endpackage

// ===== sv/two_stacks_shared_memory_core.sv =====
// Top level of the two-stack shared-memory core.
// A push, failing op or empty case goes through the operation and output registers;
// a pop also through the memory read register. A dump reads its first word the same way, then
// gives one word per cycle while out_tready holds. One item is worked on at a time; the next
// beat is taken once the current one is done.
// Synchronous active-low reset empties both stacks; memory words are not cleared.
module two_stacks_shared_memory_core #(
  parameter int DEPTH = tsm_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [2:0]                        in_tuser,   // opcode
  input  logic signed [tsm_pkg::WORD_W-1:0] in_tdata,   // push_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [1:0]                        out_tuser,  // status
  output logic signed [tsm_pkg::WORD_W-1:0] out_tdata,  // read_value
  output logic                              out_tlast
);

  tsm_pkg::cmd_t cmd;
  tsm_pkg::sts_t sts;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The controller issues at most one command in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.pop_out, cmd.dump_out}))
    else $error("more than one command issued");

  // An accepted beat blocks further input until its work is done.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.dump_out) |-> sts.slot_free)
    else $error("result loaded into a full output register");

  // A pop always delivers its word in the cycle after its read.
  a_pop_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.pop_rd) |=> cmd.pop_out)
    else $error("pop read not followed by its result");

endmodule

// ===== sv/tsm_ctrl.sv =====
// Controller state machine that sequences each operation of the core.
module tsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tsm_pkg::sts_t sts,
  output tsm_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_POPRD = 4'b0100,
    S_DUMP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.pop_out  = 1'b0;
    cmd.dump_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.slot_free) begin
          cmd.exec = 1'b1;
          if (sts.pop_rd) begin
            state_nxt = S_POPRD;
          end else if (sts.dump_rd) begin
            state_nxt = S_DUMP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_POPRD: begin
        cmd.pop_out = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DUMP: begin
        if (sts.slot_free) begin
          cmd.dump_out = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/tsm_datapath.sv =====
// Datapath with the shared word memory, stack pointers and output register.
module tsm_datapath #(
  parameter int DEPTH = tsm_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsm_pkg::cmd_t                     cmd,
  output tsm_pkg::sts_t                     sts,
  input  logic [2:0]                        in_tuser,
  input  logic signed [tsm_pkg::WORD_W-1:0] in_tdata,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [1:0]                        out_tuser,
  output logic signed [tsm_pkg::WORD_W-1:0] out_tdata,
  output logic                              out_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_C   = AW'(DEPTH - 1);

  logic [tsm_pkg::WORD_W-1:0] mem [DEPTH];
  logic [tsm_pkg::WORD_W-1:0] rd_data_r;

  tsm_pkg::op_t               op_r;
  logic [tsm_pkg::WORD_W-1:0] val_r;
  logic [CW-1:0]              count_a_r, count_a_nxt;
  logic [CW-1:0]              base_b_r, base_b_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic                       dump_b_r, dump_b_nxt;

  logic                       out_valid_r;
  tsm_pkg::status_t           out_status_r;
  logic [tsm_pkg::WORD_W-1:0] out_value_r;
  logic                       out_last_r;

  logic                       we, re, load_out;
  logic [AW-1:0]              wa, ra;
  tsm_pkg::status_t           res_status;
  logic [tsm_pkg::WORD_W-1:0] res_value;
  logic                       res_last;
  logic                       a_empty, b_empty, full;
  logic [CW-1:0]              a_dec, b_dec;

  assign a_empty = (count_a_r == '0);
  assign b_empty = (base_b_r == DEPTH_C);
  assign full    = (count_a_r >= base_b_r);
  assign a_dec   = count_a_r - CW'(1);
  assign b_dec   = base_b_r - CW'(1);

  assign sts.slot_free = !out_valid_r || out_tready;
  assign sts.pop_rd    = ((op_r == tsm_pkg::OP_POP_A) && !a_empty) ||
                         ((op_r == tsm_pkg::OP_POP_B) && !b_empty);
  assign sts.dump_rd   = ((op_r == tsm_pkg::OP_DUMP_A) && !a_empty) ||
                         ((op_r == tsm_pkg::OP_DUMP_B) && !b_empty);
  assign sts.dump_last = dump_b_r ? (CW'(ptr_r) == base_b_r) : (CW'(ptr_r) == a_dec);

  always_comb begin
    count_a_nxt = count_a_r;
    base_b_nxt  = base_b_r;
    ptr_nxt     = ptr_r;
    dump_b_nxt  = dump_b_r;
    we          = 1'b0;
    wa          = count_a_r[AW-1:0];
    re          = 1'b0;
    ra          = ptr_r;
    load_out    = 1'b0;
    res_status  = tsm_pkg::ST_OK;
    res_value   = '0;
    res_last    = 1'b1;
    if (cmd.exec) begin
      unique case (op_r)
        tsm_pkg::OP_PUSH_A: begin
          load_out = 1'b1;
          if (full) begin
            res_status = tsm_pkg::ST_FULL;
          end else begin
            we          = 1'b1;
            wa          = count_a_r[AW-1:0];
            count_a_nxt = count_a_r + CW'(1);
          end
        end
        tsm_pkg::OP_PUSH_B: begin
          load_out = 1'b1;
          if (full || base_b_r == '0) begin
            res_status = tsm_pkg::ST_FULL;
          end else begin
            we         = 1'b1;
            wa         = b_dec[AW-1:0];
            base_b_nxt = b_dec;
          end
        end
        tsm_pkg::OP_POP_A: begin
          if (a_empty) begin
            load_out   = 1'b1;
            res_status = tsm_pkg::ST_EMPTY;
          end else begin
            re          = 1'b1;
            ra          = a_dec[AW-1:0];
            count_a_nxt = a_dec;
          end
        end
        tsm_pkg::OP_POP_B: begin
          if (b_empty) begin
            load_out   = 1'b1;
            res_status = tsm_pkg::ST_EMPTY;
          end else begin
            re         = 1'b1;
            ra         = base_b_r[AW-1:0];
            base_b_nxt = base_b_r + CW'(1);
          end
        end
        tsm_pkg::OP_DUMP_A: begin
          if (a_empty) begin
            load_out   = 1'b1;
            res_status = tsm_pkg::ST_EMPTY;
          end else begin
            re         = 1'b1;
            ra         = '0;
            ptr_nxt    = '0;
            dump_b_nxt = 1'b0;
          end
        end
        tsm_pkg::OP_DUMP_B: begin
          if (b_empty) begin
            load_out   = 1'b1;
            res_status = tsm_pkg::ST_EMPTY;
          end else begin
            re         = 1'b1;
            ra         = TOP_C;
            ptr_nxt    = TOP_C;
            dump_b_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.pop_out) begin
      load_out  = 1'b1;
      res_value = rd_data_r;
    end
    if (cmd.dump_out) begin
      load_out  = 1'b1;
      res_value = rd_data_r;
      res_last  = sts.dump_last;
      if (!sts.dump_last) begin
        re      = 1'b1;
        ra      = dump_b_r ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
        ptr_nxt = ra;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= val_r;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      base_b_r    <= DEPTH_C;
      out_valid_r <= 1'b0;
    end else begin
      count_a_r   <= count_a_nxt;
      base_b_r    <= base_b_nxt;
      out_valid_r <= load_out || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= tsm_pkg::op_t'(in_tuser);
      val_r <= in_tdata;
    end
    ptr_r    <= ptr_nxt;
    dump_b_r <= dump_b_nxt;
    if (load_out) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== verif/tb_two_stacks_shared_memory_core.sv =====
// Self-checking testbench for the two-stack shared-memory core with a cycle-free stack predictor.
module tb_two_stacks_shared_memory_core;

  localparam int DEPTH = tsm_pkg::DEPTH_DEF;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    tsm_pkg::status_t status;
    logic [31:0]      value;
    logic             last;
  } stack_beat_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [2:0]                        in_tuser;   // opcode
  logic signed [tsm_pkg::WORD_W-1:0] in_tdata;   // push_value
  logic                              out_tvalid;
  logic                              out_tready;
  logic [1:0]                        out_tuser;  // status
  logic signed [tsm_pkg::WORD_W-1:0] out_tdata;  // read_value
  logic                              out_tlast;

  two_stacks_shared_memory_core #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  logic [31:0] stack_words [DEPTH];
  logic [4:0]  a_count;
  logic [4:0]  b_base;
  stack_beat_t expected_beats [$];

  int mismatch_count = 0;
  int beats_sent     = 0;
  int ignored_sent   = 0;
  int beats_checked  = 0;
  int full_answers   = 0;
  int empty_answers  = 0;
  int dump_words     = 0;
  int gap_max        = 0;
  int burst_left     = 0;
  int ready_mode     = 0;
  int hold_cycles    = 0;
  int rx_phase       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d beats still expected", $time, expected_beats.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: a long hold-off when requested, otherwise the current stall pattern.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        case (ready_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ((rx_phase % 7) < 4);
        endcase
      end
      rx_phase++;
    end
  end

  task automatic add_expected(input tsm_pkg::status_t st, input logic [31:0] val,
                              input logic lst);
    stack_beat_t b;
    b.status = st;
    b.value  = val;
    b.last   = lst;
    expected_beats.push_back(b);
    if (st == tsm_pkg::ST_FULL) full_answers++;
    if (st == tsm_pkg::ST_EMPTY) empty_answers++;
  endtask

  task automatic apply_stack_op(input logic [2:0] op, input logic [31:0] val);
    logic is_full;
    int   i;
    is_full = (a_count >= b_base);
    case (op)
      tsm_pkg::OP_PUSH_A: begin
        if (is_full) begin
          add_expected(tsm_pkg::ST_FULL, 32'd0, 1'b1);
        end else begin
          stack_words[a_count[3:0]] = val;
          a_count++;
          add_expected(tsm_pkg::ST_OK, 32'd0, 1'b1);
        end
      end
      tsm_pkg::OP_PUSH_B: begin
        if (is_full || b_base == 5'd0) begin
          add_expected(tsm_pkg::ST_FULL, 32'd0, 1'b1);
        end else begin
          b_base--;
          stack_words[b_base[3:0]] = val;
          add_expected(tsm_pkg::ST_OK, 32'd0, 1'b1);
        end
      end
      tsm_pkg::OP_POP_A: begin
        if (a_count == 5'd0) begin
          add_expected(tsm_pkg::ST_EMPTY, 32'd0, 1'b1);
        end else begin
          a_count--;
          add_expected(tsm_pkg::ST_OK, stack_words[a_count[3:0]], 1'b1);
        end
      end
      tsm_pkg::OP_POP_B: begin
        if (b_base >= DEPTH) begin
          add_expected(tsm_pkg::ST_EMPTY, 32'd0, 1'b1);
        end else begin
          add_expected(tsm_pkg::ST_OK, stack_words[b_base[3:0]], 1'b1);
          b_base++;
        end
      end
      tsm_pkg::OP_DUMP_A: begin
        if (a_count == 5'd0) begin
          add_expected(tsm_pkg::ST_EMPTY, 32'd0, 1'b1);
        end else begin
          for (i = 0; i < a_count; i++) begin
            add_expected(tsm_pkg::ST_OK, stack_words[i], (i + 1 == a_count));
            dump_words++;
          end
        end
      end
      tsm_pkg::OP_DUMP_B: begin
        if (b_base >= DEPTH) begin
          add_expected(tsm_pkg::ST_EMPTY, 32'd0, 1'b1);
        end else begin
          for (i = DEPTH - 1; i >= int'(b_base); i--) begin
            add_expected(tsm_pkg::ST_OK, stack_words[i], (i == int'(b_base)));
            dump_words++;
          end
        end
      end
      default: ignored_sent++;
    endcase
  endtask

  // Entered from a point where the next falling edge is free for a new drive.
  task automatic send_beat(input logic [2:0] op, input logic [31:0] val);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    apply_stack_op(op, val);
    beats_sent++;
    if (gap_max > 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, gap_max);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word;
    case ($urandom_range(0, 15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin : check_result
    stack_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual status=%0d value=%h last=%b",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = expected_beats.pop_front();
        if (out_tuser !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
        end
        if (out_tdata !== want.value) begin
          mismatch_count++;
          $display("%0t: value expected %h actual %h", $time, want.value, out_tdata);
        end
        if (out_tlast !== want.last) begin
          mismatch_count++;
          $display("%0t: last expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  task automatic test_empty_stacks_and_basic_ops;
    gap_max    = 3;
    ready_mode = 1;
    send_beat(tsm_pkg::OP_POP_A, random_word());
    send_beat(tsm_pkg::OP_DUMP_B, random_word());
    send_beat(tsm_pkg::OP_PUSH_A, 32'h7fff_ffff);
    send_beat(tsm_pkg::OP_PUSH_B, 32'h8000_0000);
    send_beat(tsm_pkg::OP_PUSH_A, 32'h0000_0000);
    send_beat(tsm_pkg::OP_PUSH_B, 32'hffff_ffff);
    send_beat(tsm_pkg::OP_DUMP_A, 32'h0000_0000);
    send_beat(tsm_pkg::OP_DUMP_B, 32'hffff_ffff);
    send_beat(OP_UNUSED_6, random_word());
    send_beat(OP_UNUSED_7, random_word());
    send_beat(tsm_pkg::OP_POP_A, random_word());
    send_beat(tsm_pkg::OP_POP_B, random_word());
    wait_drained();
  endtask

  // Stack B is emptied and stack A takes the whole memory while the receiver holds off.
  task automatic test_full_memory_under_backpressure;
    int i;
    gap_max     = 0;
    ready_mode  = 0;
    hold_cycles = 300;
    send_beat(tsm_pkg::OP_POP_B, random_word());
    for (i = 0; i < DEPTH - 1; i++) send_beat(tsm_pkg::OP_PUSH_A, random_word());
    send_beat(tsm_pkg::OP_PUSH_B, random_word());
    send_beat(tsm_pkg::OP_PUSH_A, random_word());
    send_beat(tsm_pkg::OP_DUMP_A, random_word());
    send_beat(tsm_pkg::OP_DUMP_B, random_word());
    wait_drained();
  endtask

  task automatic test_random_traffic;
    int          seg_len;
    int          bias;
    int          push_pct;
    int          r;
    int          counted;
    logic [2:0]  op;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      seg_len    = $urandom_range(8, 40);
      bias       = $urandom_range(0, 2);
      push_pct   = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      ready_mode = $urandom_range(0, 2);
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
        end else if (r < 13) begin
          op = $urandom_range(0, 1) ? tsm_pkg::OP_DUMP_B : tsm_pkg::OP_DUMP_A;
        end else if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? tsm_pkg::OP_PUSH_B : tsm_pkg::OP_PUSH_A;
        end else begin
          op = $urandom_range(0, 1) ? tsm_pkg::OP_POP_B : tsm_pkg::OP_POP_A;
        end
        send_beat(op, random_word());
        if (op != OP_UNUSED_6 && op != OP_UNUSED_7) counted++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = tsm_pkg::OP_PUSH_A;
    in_tdata  = '0;
    for (int i = 0; i < DEPTH; i++) stack_words[i] = '0;
    a_count = '0;
    b_base  = 5'(DEPTH);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_stacks_and_basic_ops();
    test_full_memory_under_backpressure();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input beats (%0d with unused opcodes), checked %0d result beats.",
             beats_sent, ignored_sent, beats_checked);
    $display("Saw %0d full answers, %0d empty answers and %0d dumped words.",
             full_answers, empty_answers, dump_words);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
